>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line rasterizer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, gated by reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, gated by reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/dda_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DDA rasterizer package
// Shared constants, codes and controller/datapath types.
// ---------------------------------------------------------------------------
package dda_pkg;

  localparam int PIX_BITS     = 9;
  localparam int CANVAS_BITS  = 10;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CANVAS_BITS-1:0] PIX_LIMIT    = 10'd512;
  localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = 10'd500;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_ROWS = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_COLS = 1'b1;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic div_step;
    logic div_last;
  } dp_cmd_t;

  typedef struct packed {
    logic load_zero;
  } dp_stat_t;

endpackage

>>> sv/dda_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DDA input channel
// Valid/ready channel carrying a load or advance command and two endpoints.
// ---------------------------------------------------------------------------
interface dda_in_if #(
  parameter int COORD_BITS = 11
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] row_start;
  logic signed [COORD_BITS-1:0] col_start;
  logic signed [COORD_BITS-1:0] row_end;
  logic signed [COORD_BITS-1:0] col_end;

  modport source (
    output valid, cmd, row_start, col_start, row_end, col_end,
    input  ready
  );

  modport sink (
    input  valid, cmd, row_start, col_start, row_end, col_end,
    output ready
  );
endinterface

>>> sv/dda_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DDA result channel
// Valid/ready channel carrying one rasterized pixel and line status.
// ---------------------------------------------------------------------------
interface dda_out_if;
  import dda_pkg::*;

  logic                valid;
  logic                ready;
  logic [PIX_BITS-1:0] pixel_row;
  logic [PIX_BITS-1:0] pixel_col;
  logic                pixel_valid;
  logic                line_done;

  modport source (
    output valid, pixel_row, pixel_col, pixel_valid, line_done,
    input  ready
  );

  modport sink (
    input  valid, pixel_row, pixel_col, pixel_valid, line_done,
    output ready
  );
endinterface

>>> sv/dda_line_rasterizer_core.sv
// Every transaction yields one result, registered in the cycle after acceptance.
// Throughput: advance transactions sustain one per cycle while the output is not stalled.
// A load transaction blocks input after acceptance while the radix-2 divider forms
// the increments in ST_DIV; zero-length lines skip it.
// Reset: synchronous active-low rst_n clears control, line state and canvas size to 500.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DDA line rasterizer core
// Steps a fixed-point position along a line and emits clipped pixels.
// ---------------------------------------------------------------------------
module dda_line_rasterizer_core import dda_pkg::*; #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  dda_in_if.sink                  in_if,
  dda_out_if.source               out_if,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CANVAS_BITS-1:0]  cfg_data
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  dda_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_cmd    (in_if.cmd),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  dda_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .stat        (dp_stat),
    .row_start   (in_if.row_start),
    .col_start   (in_if.col_start),
    .row_end     (in_if.row_end),
    .col_end     (in_if.col_end),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_row   (out_if.pixel_row),
    .pixel_col   (out_if.pixel_col),
    .pixel_valid (out_if.pixel_valid),
    .line_done   (out_if.line_done)
  );

endmodule

>>> sv/dda_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DDA datapath
// Endpoint setup, radix-2 increment division, position stepping,
// pixel rounding, canvas clipping and the result register.
// ---------------------------------------------------------------------------
module dda_datapath import dda_pkg::*; #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dp_cmd_t                      cmd,
  output dp_stat_t                     stat,
  input  logic signed [COORD_BITS-1:0] row_start,
  input  logic signed [COORD_BITS-1:0] col_start,
  input  logic signed [COORD_BITS-1:0] row_end,
  input  logic signed [COORD_BITS-1:0] col_end,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CANVAS_BITS-1:0]       cfg_data,
  output logic [PIX_BITS-1:0]          pixel_row,
  output logic [PIX_BITS-1:0]          pixel_col,
  output logic                         pixel_valid,
  output logic                         line_done
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = COORD_BITS + FRAC_BITS + 1;
  localparam int IW = FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int NW = COORD_BITS + FRAC_BITS + 1;
  localparam int RW = PW + 1 - FRAC_BITS;

  localparam logic [PW:0] HALF =
    {{(PW + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

  logic [CANVAS_BITS-1:0] canvas_rows_r, canvas_rows_nxt;
  logic [CANVAS_BITS-1:0] canvas_cols_r, canvas_cols_nxt;

  logic signed [PW-1:0]   pos_r       [2];
  logic signed [PW-1:0]   pos_nxt     [2];
  logic signed [IW-1:0]   inc_r       [2];
  logic signed [IW-1:0]   inc_nxt     [2];
  logic [COORD_BITS-1:0]  rem_r       [2];
  logic [COORD_BITS-1:0]  rem_nxt     [2];
  logic [QW-1:0]          qd_r        [2];
  logic [QW-1:0]          qd_nxt      [2];
  logic                   neg_r       [2];
  logic                   neg_nxt     [2];
  logic [COORD_BITS-1:0]  steps_left_r, steps_left_nxt;

  logic [PIX_BITS-1:0]    pixel_row_r, pixel_row_nxt;
  logic [PIX_BITS-1:0]    pixel_col_r, pixel_col_nxt;
  logic                   pixel_valid_r, pixel_valid_nxt;
  logic                   line_done_r, line_done_nxt;

  logic signed [DW-1:0]   delta    [2];
  logic [DW-1:0]          delta_abs[2];
  logic [COORD_BITS-1:0]  mag      [2];
  logic [COORD_BITS-1:0]  steps;
  logic [NW-1:0]          dividend [2];
  logic [COORD_BITS:0]    trial    [2];
  logic                   fits     [2];
  logic signed [PW-1:0]   pos_adv  [2];
  logic [PW:0]            rnd_sum  [2];
  logic [RW-1:0]          rnd      [2];
  logic [CANVAS_BITS-1:0] row_lim;
  logic [CANVAS_BITS-1:0] col_lim;
  logic                   in_canvas;

  always_comb begin
    canvas_rows_nxt = canvas_rows_r;
    canvas_cols_nxt = canvas_cols_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CANVAS_ROWS: canvas_rows_nxt = cfg_data;
        CFG_CANVAS_COLS: canvas_cols_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  assign row_lim = (canvas_rows_r > PIX_LIMIT) ? PIX_LIMIT : canvas_rows_r;
  assign col_lim = (canvas_cols_r > PIX_LIMIT) ? PIX_LIMIT : canvas_cols_r;

  assign delta[0] = DW'(row_end) - DW'(row_start);
  assign delta[1] = DW'(col_end) - DW'(col_start);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      delta_abs[i] = delta[i][DW-1] ? -delta[i] : delta[i];
      mag[i]       = delta_abs[i][COORD_BITS-1:0];
    end
    steps = (mag[0] > mag[1]) ? mag[0] : mag[1];
    for (int i = 0; i < 2; i++) begin
      dividend[i] = NW'({mag[i], {FRAC_BITS{1'b0}}}) + NW'(steps >> 1);
      trial[i]    = {rem_r[i], qd_r[i][QW-1]};
      fits[i]     = trial[i] >= {1'b0, steps_left_r};
      pos_adv[i]  = pos_r[i] + PW'(inc_r[i]);
      rnd_sum[i]  = (PW + 1)'(pos_adv[i]) + HALF;
      rnd[i]      = rnd_sum[i][PW:FRAC_BITS];
    end
  end

  assign stat.load_zero = (steps == '0);

  assign in_canvas = !rnd[0][RW-1] && !rnd[1][RW-1] &&
                     (rnd[0] < RW'(row_lim)) && (rnd[1] < RW'(col_lim));

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      pos_nxt[i] = pos_r[i];
      inc_nxt[i] = inc_r[i];
      rem_nxt[i] = rem_r[i];
      qd_nxt[i]  = qd_r[i];
      neg_nxt[i] = neg_r[i];
    end
    steps_left_nxt  = steps_left_r;
    pixel_row_nxt   = pixel_row_r;
    pixel_col_nxt   = pixel_col_r;
    pixel_valid_nxt = pixel_valid_r;
    line_done_nxt   = line_done_r;

    if (cmd.load) begin
      pos_nxt[0] = {DW'(row_start), {FRAC_BITS{1'b0}}};
      pos_nxt[1] = {DW'(col_start), {FRAC_BITS{1'b0}}};
      for (int i = 0; i < 2; i++) begin
        inc_nxt[i] = '0;
        rem_nxt[i] = dividend[i][NW-1:QW];
        qd_nxt[i]  = dividend[i][QW-1:0];
        neg_nxt[i] = delta[i][DW-1];
      end
      steps_left_nxt  = steps;
      pixel_row_nxt   = '0;
      pixel_col_nxt   = '0;
      pixel_valid_nxt = 1'b0;
      line_done_nxt   = (steps == '0);
    end else if (cmd.advance) begin
      pixel_row_nxt   = '0;
      pixel_col_nxt   = '0;
      pixel_valid_nxt = 1'b0;
      if (steps_left_r == '0) begin
        line_done_nxt = 1'b1;
      end else begin
        for (int i = 0; i < 2; i++) begin
          pos_nxt[i] = pos_adv[i];
        end
        steps_left_nxt = steps_left_r - 1'b1;
        line_done_nxt  = (steps_left_r == COORD_BITS'(1));
        if (in_canvas) begin
          pixel_row_nxt   = rnd[0][PIX_BITS-1:0];
          pixel_col_nxt   = rnd[1][PIX_BITS-1:0];
          pixel_valid_nxt = 1'b1;
        end
      end
    end else if (cmd.div_step) begin
      for (int i = 0; i < 2; i++) begin
        rem_nxt[i] = COORD_BITS'(fits[i] ? (trial[i] - {1'b0, steps_left_r})
                                         : trial[i]);
        qd_nxt[i]  = {qd_r[i][QW-2:0], fits[i]};
        if (cmd.div_last) begin
          inc_nxt[i] = neg_r[i] ? -IW'(qd_nxt[i]) : IW'(qd_nxt[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_rows_r <= CANVAS_RESET;
      canvas_cols_r <= CANVAS_RESET;
      steps_left_r  <= '0;
      for (int i = 0; i < 2; i++) begin
        pos_r[i] <= '0;
        inc_r[i] <= '0;
      end
    end else begin
      canvas_rows_r <= canvas_rows_nxt;
      canvas_cols_r <= canvas_cols_nxt;
      steps_left_r  <= steps_left_nxt;
      for (int i = 0; i < 2; i++) begin
        pos_r[i] <= pos_nxt[i];
        inc_r[i] <= inc_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      rem_r[i] <= rem_nxt[i];
      qd_r[i]  <= qd_nxt[i];
      neg_r[i] <= neg_nxt[i];
    end
    pixel_row_r   <= pixel_row_nxt;
    pixel_col_r   <= pixel_col_nxt;
    pixel_valid_r <= pixel_valid_nxt;
    line_done_r   <= line_done_nxt;
  end

  assign pixel_row   = pixel_row_r;
  assign pixel_col   = pixel_col_r;
  assign pixel_valid = pixel_valid_r;
  assign line_done   = line_done_r;

endmodule

>>> sv/dda_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DDA controller
// Handshake control, division sequencing and result register valid.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dda_ctrl import dda_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int CW = $clog2(FRAC_BITS + 1);

  ctrl_state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    in_ready     = 1'b0;
    cmd          = '0;
    accept       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = !out_valid_r || out_ready;
        accept      = in_valid && in_ready;
        cmd.load    = accept && (in_cmd == CMD_LOAD);
        cmd.advance = accept && (in_cmd == CMD_ADVANCE);
        if (cmd.load && !stat.load_zero) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = (cnt_r == CW'(FRAC_BITS));
        cnt_nxt      = cnt_r + 1'b1;
        if (cmd.div_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

  `ASSERT_IMPLIES(a_no_accept_in_div, clk, rst_n, state_r == ST_DIV, !in_ready)
  `ASSERT_NEXT(a_div_last_idle, clk, rst_n, cmd.div_last, state_r == ST_IDLE)
  `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid_r)
  `ASSERT_IMPLIES(a_cnt_bound, clk, rst_n, state_r == ST_DIV, cnt_r <= CW'(FRAC_BITS))

endmodule
